// ===== design/bhpq_pkg.sv =====
package bhpq_pkg;

	// default sizes
	localparam int DEPTH_DEF       = 64;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	// configuration port
	localparam int CFG_IDX_WIDTH  = 1;
	localparam int CFG_WIDTH      = 7;
	localparam int CAP_WIDTH      = 7;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_HEAP_ORDER = 1'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_CAPACITY   = 1'd1;
	localparam logic [CAP_WIDTH-1:0]     CAP_RESET      = 7'd64;

	// heap order
	localparam logic ORDER_MIN = 1'b0;
	localparam logic ORDER_MAX = 1'b1;

	// operation codes
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	// result status codes
	localparam int STATUS_WIDTH = 2;
	localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

endpackage

// ===== design/bhpq_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
module bhpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== design/binary_heap_priority_queue.sv =====
// Channel   Direction  Payload
// s_axis    in         tuser: operation; tdata: key, value
// m_axis    out        tuser: status; tdata: out_key, out_value, entry_count
// cfg       in         cfg_index 0 heap_order, 1 capacity_limit; no read-back
//
// One operation at a time. The heap lives in a RAM with two registered read
// ports, so a sift-down step reads both children at once. An insert climbs in
// S_UP, then S_PLACE if it reaches the root, then S_FIN. An extract takes the
// root and last entry in S_EXT, descends in S_DOWN, S_PLACE if it hits the
// bottom, then S_FIN; with at most one entry left it goes S_EXT to S_FIN. Refused
// ops and inserts into an empty heap go straight to S_FIN. Reset clears the
// count and config only; no clearing pass. A stalled result holds the block in S_FIN.
module binary_heap_priority_queue #(
	parameter int DEPTH       = bhpq_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH   = bhpq_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = bhpq_pkg::VALUE_WIDTH_DEF,
	localparam int CW    = $clog2(DEPTH + 1),
	localparam int EW    = KEY_WIDTH + VALUE_WIDTH,
	localparam int IN_W  = ((EW + 7) / 8) * 8,
	localparam int OUT_W = ((EW + CW + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input transactions
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [IN_W-1:0]                     s_axis_tdata,  // key, value
	input  logic                                s_axis_tuser,  // operation
	// result transactions
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [OUT_W-1:0]                    m_axis_tdata,  // out_key, out_value, entry_count
	output logic [bhpq_pkg::STATUS_WIDTH-1:0]   m_axis_tuser,  // status
	// configuration writes
	input  logic                                cfg_we,
	input  logic [bhpq_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [bhpq_pkg::CFG_WIDTH-1:0]      cfg_data
);

	import bhpq_pkg::*;

	localparam int KW = KEY_WIDTH;
	localparam int VW = VALUE_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam int XW = AW + 2;
	localparam int LW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UP    = 3'd1;
	localparam logic [2:0] S_EXT   = 3'd2;
	localparam logic [2:0] S_DOWN  = 3'd3;
	localparam logic [2:0] S_PLACE = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	// true when the child key must rise above the parent key
	function automatic logic must_swap(input logic order, input logic [KW-1:0] parent,
			input logic [KW-1:0] child);
		if (order == ORDER_MAX) begin
			return $signed(parent) < $signed(child);
		end
		return $signed(parent) > $signed(child);
	endfunction

	// control state
	logic [2:0]           state_q;
	logic [CW-1:0]        fill_q;
	logic                 order_q;
	logic [CAP_WIDTH-1:0] cap_q;
	logic                 out_valid_q;

	// working registers
	logic [AW-1:0]           pos_q;
	logic [KW-1:0]           item_key_q;
	logic [VW-1:0]           item_val_q;
	logic [STATUS_WIDTH-1:0] res_status_q;
	logic [KW-1:0]           res_key_q;
	logic [VW-1:0]           res_val_q;
	logic [STATUS_WIDTH-1:0] out_status_q;
	logic [KW-1:0]           out_key_q;
	logic [VW-1:0]           out_val_q;
	logic [CW-1:0]           out_count_q;

	// memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;
	logic [EW-1:0] rd_data_a;
	logic [EW-1:0] rd_data_b;

	logic          s_op;
	logic [KW-1:0] s_key;
	logic [VW-1:0] s_val;
	logic          in_acc;
	logic          out_free;
	logic [LW-1:0] cap_ext;
	logic [LW-1:0] limit;
	logic          full;

	logic [AW-1:0] par_of_fill;
	logic [AW-1:0] par_of_pos;
	logic [AW-1:0] par_of_par;
	logic          up_swap;
	logic [XW-1:0] fill_x;
	logic [XW-1:0] left_x;
	logic [XW-1:0] right_x;
	logic          right_ok;
	logic          pick_right;
	logic [EW-1:0] pick_ent;
	logic [AW-1:0] pick_idx;
	logic          down_swap;
	logic [XW-1:0] next_left_x;
	logic          next_more;
	logic [EW-1:0] item_ent;

	bhpq_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(rd_addr_a),
		.raddr_b(rd_addr_b),
		.rdata_a(rd_data_a),
		.rdata_b(rd_data_b)
	);

	// port unpacking and handshakes
	assign s_op          = s_axis_tuser;
	assign s_key         = s_axis_tdata[KW-1:0];
	assign s_val         = s_axis_tdata[EW-1:KW];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;

	always_comb begin
		m_axis_tdata              = '0;
		m_axis_tdata[KW-1:0]      = out_key_q;
		m_axis_tdata[EW-1:KW]     = out_val_q;
		m_axis_tdata[EW+CW-1:EW]  = out_count_q;
	end

	// capacity, clamped to the store depth
	assign cap_ext = LW'(cap_q);
	assign limit   = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
	assign full    = LW'(fill_q) >= limit;

	// sift-up: compare the held item against the parent just read
	assign par_of_fill = AW'((fill_q - CW'(1)) >> 1);
	assign par_of_pos  = (pos_q - AW'(1)) >> 1;
	assign par_of_par  = (par_of_pos - AW'(1)) >> 1;
	assign up_swap     = must_swap(order_q, rd_data_a[KW-1:0], item_key_q);

	// sift-down: pick a child, compare the held item against it
	assign fill_x      = XW'(fill_q);
	assign left_x      = (XW'(pos_q) << 1) + XW'(1);
	assign right_x     = left_x + XW'(1);
	assign right_ok    = right_x < fill_x;
	assign pick_right  = right_ok && ((order_q == ORDER_MAX) ?
			($signed(rd_data_a[KW-1:0]) <= $signed(rd_data_b[KW-1:0])) :
			($signed(rd_data_a[KW-1:0]) > $signed(rd_data_b[KW-1:0])));
	assign pick_ent    = pick_right ? rd_data_b : rd_data_a;
	assign pick_idx    = pick_right ? AW'(right_x) : AW'(left_x);
	assign down_swap   = must_swap(order_q, item_key_q, pick_ent[KW-1:0]);
	assign next_left_x = (XW'(pick_idx) << 1) + XW'(1);
	assign next_more   = next_left_x < fill_x;
	assign item_ent    = {item_val_q, item_key_q};

	// memory addressing and write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = item_ent;
		rd_addr_a = par_of_pos;
		rd_addr_b = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_addr_a = (s_op == OP_INSERT) ? par_of_fill : '0;
				rd_addr_b = AW'(fill_q - CW'(1));
				if (in_acc && s_op == OP_INSERT && !full && fill_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = {s_val, s_key};
				end
			end
			S_UP: begin
				rd_addr_a = par_of_par;
				mem_we    = 1'b1;
				if (up_swap) begin
					mem_wdata = rd_data_a;
				end
			end
			S_EXT: begin
				rd_addr_a = AW'(1);
				rd_addr_b = AW'(2);
				if (fill_q == CW'(1)) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = rd_data_b;
				end
			end
			S_DOWN: begin
				rd_addr_a = AW'(next_left_x);
				rd_addr_b = AW'(next_left_x + XW'(1));
				mem_we    = 1'b1;
				if (down_swap) begin
					mem_wdata = pick_ent;
				end
			end
			S_PLACE: begin
				mem_we = 1'b1;
			end
			S_FIN: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// control: sequencer, count, configuration, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			order_q     <= ORDER_MIN;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEAP_ORDER: order_q <= cfg_data[0];
					CFG_CAPACITY:   cap_q   <= cfg_data[CAP_WIDTH-1:0];
					default:        cap_q   <= cap_q;
				endcase
			end
			// result register: load at the end of an operation, else drain
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_op == OP_INSERT) begin
							if (full) begin
								state_q <= S_FIN;
							end else begin
								fill_q  <= fill_q + CW'(1);
								state_q <= (fill_q == '0) ? S_FIN : S_UP;
							end
						end else begin
							if (fill_q == '0) begin
								state_q <= S_FIN;
							end else begin
								fill_q  <= fill_q - CW'(1);
								state_q <= S_EXT;
							end
						end
					end
				end
				S_UP: begin
					if (!up_swap) begin
						state_q <= S_FIN;
					end else if (par_of_pos == '0) begin
						state_q <= S_PLACE;
					end
				end
				S_EXT: begin
					state_q <= (fill_q <= CW'(1)) ? S_FIN : S_DOWN;
				end
				S_DOWN: begin
					if (!down_swap) begin
						state_q <= S_FIN;
					end else if (!next_more) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: held item, hole position, result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					item_key_q <= s_key;
					item_val_q <= s_val;
					pos_q      <= AW'(fill_q);
					res_key_q  <= '0;
					res_val_q  <= '0;
					if (s_op == OP_INSERT) begin
						res_status_q <= full ? ST_FULL : ST_OK;
					end else begin
						res_status_q <= (fill_q == '0) ? ST_EMPTY : ST_OK;
					end
				end
			end
			S_UP: begin
				if (up_swap) begin
					pos_q <= par_of_pos;
				end
			end
			S_EXT: begin
				res_key_q  <= rd_data_a[KW-1:0];
				res_val_q  <= rd_data_a[EW-1:KW];
				item_key_q <= rd_data_b[KW-1:0];
				item_val_q <= rd_data_b[EW-1:KW];
				pos_q      <= '0;
			end
			S_DOWN: begin
				if (down_swap) begin
					pos_q <= pick_idx;
				end
			end
			S_PLACE: begin
				pos_q <= pos_q;
			end
			S_FIN: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_key_q    <= res_key_q;
					out_val_q    <= res_val_q;
					out_count_q  <= fill_q;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_down_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DOWN && mem_we) |-> (mem_waddr != rd_addr_a))
		else $error("sift-down writes the entry it reads");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_op == OP_INSERT && !full) |=> (fill_q == $past(fill_q) + CW'(1)))
		else $error("accepted insert did not grow the count");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_EMPTY) |-> (out_count_q == '0))
		else $error("empty refusal with nonzero count");

endmodule

// ===== dv/bhpq_checker.sv =====
module bhpq_checker
	import bhpq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	input  logic [63:0]              s_axis_tdata,   // key, value
	input  logic                     s_axis_tuser,   // operation
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic [71:0]              m_axis_tdata,   // out_key, out_value, entry_count
	input  logic [STATUS_WIDTH-1:0]  m_axis_tuser,   // status
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]     cfg_data,
	output int                       mismatch_count,
	output int                       results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = DEPTH_DEF;

	typedef struct {
		logic [STATUS_WIDTH-1:0] status;
		logic signed [31:0]      key;
		logic [31:0]             value;
		logic [6:0]              count;
	} heap_result_t;

	// shadow heap and its settings
	logic signed [31:0] heap_key [SLOTS];
	logic [31:0]        heap_val [SLOTS];
	int unsigned        fill;
	logic               order_sel;
	logic [CAP_WIDTH-1:0] cap_limit;

	heap_result_t predicted_results[$];

	// true when child has to move above parent; equal keys stay put
	function automatic bit outranks(logic signed [31:0] child, logic signed [31:0] parent);
		return (order_sel == ORDER_MAX) ? (child > parent) : (child < parent);
	endfunction

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic signed [31:0] k;
		logic [31:0]        v;
		k = heap_key[a];
		v = heap_val[a];
		heap_key[a] = heap_key[b];
		heap_val[a] = heap_val[b];
		heap_key[b] = k;
		heap_val[b] = v;
	endfunction

	// apply one operation to the shadow heap, return what the block must report
	function automatic heap_result_t apply_heap_op(logic op, logic signed [31:0] key,
			logic [31:0] value);
		heap_result_t r;
		int unsigned  lim, pos, parent, left, right, pick;
		r.status = ST_OK;
		r.key    = '0;
		r.value  = '0;
		lim = (cap_limit > SLOTS) ? SLOTS : cap_limit;
		if (op == OP_INSERT) begin
			if (fill >= lim) begin
				r.status = ST_FULL;
			end else begin
				heap_key[fill] = key;
				heap_val[fill] = value;
				pos = fill;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (!outranks(heap_key[pos], heap_key[parent]))
						break;
					swap_slots(parent, pos);
					pos = parent;
				end
				fill++;
			end
		end else if (fill == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.key   = heap_key[0];
			r.value = heap_val[0];
			fill--;
			if (fill > 0) begin
				heap_key[0] = heap_key[fill];
				heap_val[0] = heap_val[fill];
				pos = 0;
				while (2 * pos + 1 < fill) begin
					left  = 2 * pos + 1;
					right = left + 1;
					pick  = left;
					// tied children: max-heap takes right, min-heap takes left
					if (right < fill && ((order_sel == ORDER_MAX) ?
							(heap_key[left] <= heap_key[right]) :
							(heap_key[left] > heap_key[right])))
						pick = right;
					if (!outranks(heap_key[pick], heap_key[pos]))
						break;
					swap_slots(pos, pick);
					pos = pick;
				end
			end
		end
		r.count = 7'(fill);
		return r;
	endfunction

	// monitor: results first, then config writes, then new transactions
	always @(posedge clk or negedge arst_n) begin : monitor
		heap_result_t want, got;
		bit           bad;
		if (!arst_n) begin
			fill      = 0;
			order_sel = ORDER_MIN;
			cap_limit = CAP_RESET;
			foreach (heap_key[i]) begin
				heap_key[i] = '0;
				heap_val[i] = '0;
			end
			predicted_results.delete();
			mismatch_count  = 0;
			results_pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tuser;
				got.key    = m_axis_tdata[31:0];
				got.value  = m_axis_tdata[63:32];
				got.count  = m_axis_tdata[70:64];
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result: status %0d key %0d value %h count %0d",
							$realtime, got.status, got.key, got.value, got.count);
				end else begin
					want = predicted_results.pop_front();
					bad  = (got.status !== want.status) || (got.key !== want.key) ||
						(got.value !== want.value) || (got.count !== want.count);
					if (bad) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%0t: result mismatch (expected/actual): status %0d/%0d",
								" key %0d/%0d value %h/%h count %0d/%0d"}, $realtime,
								want.status, got.status, want.key, got.key,
								want.value, got.value, want.count, got.count);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_HEAP_ORDER)
					order_sel = cfg_data[0];
				else if (cfg_index == CFG_CAPACITY)
					cap_limit = cfg_data[CAP_WIDTH-1:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				predicted_results.push_back(apply_heap_op(s_axis_tuser,
					s_axis_tdata[31:0], s_axis_tdata[63:32]));
			results_pending = predicted_results.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	import bhpq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 1000;  // cycles without any transaction
	localparam int SETTLE      = 16;    // idle cycles after the last result

	logic                     clk;
	logic                     arst_n        = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [63:0]              s_axis_tdata  = '0;   // key, value
	logic                     s_axis_tuser  = 1'b0; // operation
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [71:0]              m_axis_tdata;         // out_key, out_value, entry_count
	logic [STATUS_WIDTH-1:0]  m_axis_tuser;         // status
	logic                     cfg_we        = 1'b0;
	logic [CFG_IDX_WIDTH-1:0] cfg_index     = '0;
	logic [CFG_WIDTH-1:0]     cfg_data      = '0;

	int mismatch_count;
	int results_pending;
	int burst_left  = 0;
	int quiet_cycles = 0;

	binary_heap_priority_queue u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	bhpq_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: ready runs broken by stalls of random length
	initial begin : rx_pattern
		int ready_run, stall_run;
		forever begin
			ready_run = $urandom_range(1, 24);
			stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (ready_run) begin
				@(negedge clk);
				m_axis_tready <= 1'b1;
			end
			repeat (stall_run) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// one transaction, then a gap when the current burst runs out
	task automatic send_op(logic op, logic [31:0] key, logic [31:0] value);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {value, key};
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 12);
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic push_entry(logic [31:0] key, logic [31:0] value);
		send_op(OP_INSERT, key, value);
	endtask

	task automatic pop_root();
		send_op(OP_EXTRACT, $urandom(), $urandom());
	endtask

	// stop sending and wait until every result is back
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (results_pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic configure(logic order, logic [CAP_WIDTH-1:0] cap);
		drain();
		write_reg(CFG_HEAP_ORDER, CFG_WIDTH'(order));
		write_reg(CFG_CAPACITY, cap);
	endtask

	// keys lean toward a narrow band so that ties are frequent
	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2, 3, 4: return $urandom_range(0, 8) - 32'd4;
			default: return $urandom();
		endcase
	endfunction

	task automatic random_ops(int n, int insert_pct);
		repeat (n) begin
			if ($urandom_range(0, 99) < insert_pct)
				push_entry(pick_key(), $urandom());
			else
				pop_root();
		end
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: min-heap, full capacity
		pop_root();                           // empty heap
		push_entry(32'h8000_0000, 32'h0000_0000);
		push_entry(32'h7fff_ffff, 32'hffff_ffff);
		push_entry(32'h0000_0000, 32'h5a5a_5a5a);
		push_entry(32'hffff_ffff, 32'ha5a5_a5a5);
		push_entry(32'h8000_0000, 32'h0000_0001); // equal to root, must not climb
		repeat (5) pop_root();                // last pop leaves the heap empty
		// min-heap tied children: left one wins
		push_entry(32'd1, 32'd10);
		push_entry(32'd5, 32'd11);
		push_entry(32'd5, 32'd12);
		push_entry(32'd9, 32'd13);
		repeat (4) pop_root();

		// max-heap, capacity above the array size
		configure(ORDER_MAX, 7'd127);
		push_entry(32'd9, 32'd20);
		push_entry(32'd5, 32'd21);
		push_entry(32'd5, 32'd22);
		push_entry(32'd1, 32'd23);
		repeat (2) pop_root();                // tie goes to the right child
		random_ops(120, 70);                  // mostly inserts, so the heap grows

		// capacity far below the current count, order flipped on a live heap
		configure(ORDER_MIN, 7'd2);
		random_ops(40, 50);

		// capacity zero refuses every insert
		configure(ORDER_MAX, 7'd0);
		random_ops(20, 60);

		configure(ORDER_MIN, 7'd1);
		random_ops(30, 50);

		repeat (3) begin
			configure(1'($urandom_range(0, 1)), 7'($urandom_range(3, 63)));
			random_ops(50, 55);
		end

		configure(ORDER_MIN, CAP_RESET);
		random_ops(140, 45);

		drain();
		if (mismatch_count == 0 && results_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
